// File: design/lkvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Shared field types, operation codes and constants of the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  // Fixed field widths
  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  typedef logic signed [KEY_W-1:0]  key_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic        [CAP_W-1:0]  cap_t;

  // Operation codes
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  // Capacity after reset
  localparam cap_t CAP_RESET = cap_t'(16);

  // Read value returned by a get that misses, and by any put
  localparam data_t MISS_VALUE = data_t'(-1);
  localparam data_t PUT_VALUE  = data_t'(0);

endpackage

// File: design/lru_key_value_cache_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key/value cache core
// Fully associative key/value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Takes one get or put request per cycle while the result channel does not stall
// and returns one result per request. The request register loads on acceptance
// and the result register loads from it once the result register is free.
// All ENTRIES keys are compared in parallel against the registered request,
// and the age rank of every entry (0 = most recent) is updated in the same
// cycle, so back-to-back requests see each other's effects. The result
// register lets a new request enter while a finished result waits. Storage is
// flip-flops: slots fill in order, so a slot is in use exactly when its index
// is below the fill count, and the oldest entry is the one whose rank equals
// the fill count minus one. The capacity register limits how many slots fill
// before eviction starts; 0 acts as 1 and values above ENTRIES act as ENTRIES.
// Write it only while no request is in flight.
module lru_key_value_cache_core #(
  parameter int ENTRIES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // capacity register
  input  logic                  cfg_we_i,
  input  lkvc_pkg::cap_t        cfg_wdata_i,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  opcode_i,
  input  lkvc_pkg::key_t        lookup_key_i,
  input  lkvc_pkg::data_t       store_value_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  hit_o,
  output lkvc_pkg::data_t       read_value_o
);

  import lkvc_pkg::*;

  localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  localparam logic [CMPW-1:0] ENTRIES_C = CMPW'(ENTRIES);

  // Configuration
  cap_t cap_q;

  // Request register
  logic  req_valid_q;
  op_e   req_op_q;
  key_t  req_key_q;
  data_t req_value_q;

  // Result register
  logic  res_valid_q;
  logic  res_hit_q;
  data_t res_value_q;

  // Entry storage
  key_t          key_q  [ENTRIES];
  data_t         data_q [ENTRIES];
  logic [AW-1:0] age_q  [ENTRIES];
  logic [AW-1:0] age_d  [ENTRIES];
  logic [CW-1:0] fill_q;
  logic [CW-1:0] fill_d;

  // Lookup and update control
  logic                advance;
  logic                accept;
  logic                fire;
  logic                is_put;
  logic                found;
  logic                evict;
  logic                do_update;
  logic [ENTRIES-1:0]  valid_vec;
  logic [ENTRIES-1:0]  match_vec;
  logic [ENTRIES-1:0]  oldest_vec;
  logic [ENTRIES-1:0]  insert_vec;
  logic [ENTRIES-1:0]  target_vec;
  logic [AW-1:0]       hit_age;
  data_t               hit_data;
  logic [CW-1:0]       thresh;
  logic [CMPW-1:0]     eff_cap;
  logic [CMPW-1:0]     cap_ext;
  data_t               res_value_d;

  // Handshake: the request stage moves on when the result register is free
  assign advance     = !res_valid_q || !out_stall_i;
  assign in_stall_o  = req_valid_q && !advance;
  assign accept      = in_valid_i && !in_stall_o;
  assign fire        = req_valid_q && advance;
  assign out_valid_o = res_valid_q;
  assign hit_o       = res_hit_q;
  assign read_value_o = res_value_q;

  // Hold the capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Capture a request when the stage is free or draining
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_op_q    <= op_e'(opcode_i);
      req_key_q   <= lookup_key_i;
      req_value_q <= store_value_i;
    end
  end

  // Parallel tag compare, oldest and free slot decode
  always_comb begin
    hit_age  = '0;
    hit_data = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      valid_vec[i]  = CW'(i) < fill_q;
      match_vec[i]  = valid_vec[i] && (key_q[i] == req_key_q);
      oldest_vec[i] = valid_vec[i] && (CW'(age_q[i]) == (fill_q - CW'(1)));
      insert_vec[i] = CW'(i) == fill_q;
      hit_age  = hit_age  | (age_q[i]  & {AW{match_vec[i]}});
      hit_data = hit_data | (data_q[i] & {DATA_W{match_vec[i]}});
    end
  end

  // Clamp capacity into 1..ENTRIES and decide insert or evict
  always_comb begin
    cap_ext = CMPW'(cap_q);
    if (cap_ext == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_ext > ENTRIES_C) begin
      eff_cap = ENTRIES_C;
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign is_put    = (req_op_q == OP_PUT);
  assign found     = |match_vec;
  assign evict     = !found && (CMPW'(fill_q) >= eff_cap);
  assign do_update = fire && (found || is_put);

  // Pick the slot to touch and the rank below which entries age
  always_comb begin
    if (found) begin
      target_vec = match_vec;
      thresh     = CW'(hit_age);
    end else if (evict) begin
      target_vec = oldest_vec;
      thresh     = fill_q - CW'(1);
    end else begin
      target_vec = insert_vec;
      thresh     = fill_q;
    end
  end

  // Age update: target becomes most recent, younger entries age by one
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      age_d[i] = age_q[i];
      if (do_update) begin
        if (target_vec[i]) begin
          age_d[i] = '0;
        end else if (valid_vec[i] && (CW'(age_q[i]) < thresh)) begin
          age_d[i] = age_q[i] + AW'(1);
        end
      end
    end
    fill_d = fill_q;
    if (do_update && is_put && !found && !evict) begin
      fill_d = fill_q + CW'(1);
    end
  end

  // Hold ranks and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      fill_q <= fill_d;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= age_d[i];
      end
    end
  end

  // Write value on any put, key only on insert or evict
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (fire && is_put && target_vec[i]) begin
        data_q[i] <= req_value_q;
        if (!found) begin
          key_q[i] <= req_key_q;
        end
      end
    end
  end

  // Form the result
  always_comb begin
    if (is_put) begin
      res_value_d = PUT_VALUE;
    end else if (found) begin
      res_value_d = hit_data;
    end else begin
      res_value_d = MISS_VALUE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_hit_q   <= found;
      res_value_q <= res_value_d;
    end
  end

endmodule
